// ===== rtl/core/ppd_pkg.sv =====
// Shared types and constants for the probe packet deframer.
// Used by ppd_emit and probe_packet_deframer; depends on nothing else.
`default_nettype none

package ppd_pkg;

  // default framing geometry
  localparam int WORDS_PER_PACKET_DEF  = 153;
  localparam int PACKETS_PER_BLOCK_DEF = 12;
  localparam int AP_CHANNELS_DEF       = 384;
  localparam int LFP_PER_PACKET_DEF    = 32;
  localparam int LFP_WORD_LIMIT_DEF    = 13;

  // fixed field widths
  localparam int CODE_W  = 10;
  localparam int CHAN_W  = 9;
  localparam int VAL_W   = 16;
  localparam int STAMP_W = 63;
  localparam int TIME_W  = 64;
  localparam int EVT_W   = 16;
  localparam int GRP_W   = 4;
  localparam int SCALE_W = 24;
  localparam int SECS_W  = 16;
  localparam int BLK_W   = 32;
  localparam int NSMP    = 3;

  // scale register reset values (gain 500 for AP, gain 250 for LFP)
  localparam logic [SCALE_W-1:0] AP_SCALE_RST  = 24'd787692;
  localparam logic [SCALE_W-1:0] LFP_SCALE_RST = 24'd1575385;
  localparam int BLOCKS_PER_SECOND = 2500;

  // sample code midpoint
  localparam logic [CODE_W-1:0] CODE_MID = 10'd512;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AP_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LFP_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_LIMIT = 2'd2;

  // pending result slots: samples, corrupt, file split, then event bits
  localparam int P_SMP0    = 0;
  localparam int P_CORRUPT = 3;
  localparam int P_SPLIT   = 4;
  localparam int P_EVT0    = 5;
  localparam int PEND_W    = P_EVT0 + EVT_W;

  typedef enum logic [1:0] {
    KIND_AP      = 2'd0,
    KIND_LFP     = 2'd1,
    KIND_EVENT   = 2'd2,
    KIND_CORRUPT = 2'd3
  } kind_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] raw_word;
  } in_t;

  typedef struct packed {
    kind_t                     kind;
    logic [CHAN_W-1:0]         channel;
    logic signed [VAL_W-1:0]   value;
    logic [STAMP_W-1:0]        stamp;
    logic                      last;
  } out_t;

  // payload of one decoded item, held while its results drain
  typedef struct packed {
    logic                          lfp;
    logic [NSMP-1:0][CODE_W-1:0]   code;
    logic [NSMP-1:0][CHAN_W-1:0]   chan;
    logic [EVT_W-1:0]              evt_code;
    logic [STAMP_W-1:0]            stamp;
    logic [STAMP_W-1:0]            bad_stamp;
  } work_t;

endpackage

`default_nettype wire

// ===== rtl/core/ppd_emit.sv =====
// Result serializer: holds one decoded item and sends its results one per cycle
// unless stalled. Scales samples with a single multiplier; depends on ppd_pkg.
`default_nettype none

module ppd_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [ppd_pkg::PEND_W-1:0]    load_pend,
  input  wire ppd_pkg::work_t                load_work,
  output logic                               take_ok,
  input  wire logic [ppd_pkg::SCALE_W-1:0]   ap_scale,
  input  wire logic [ppd_pkg::SCALE_W-1:0]   lfp_scale,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ppd_pkg::out_t                      out_data
);

  localparam int PROD_W = ppd_pkg::CODE_W + ppd_pkg::SCALE_W;
  localparam int MAG_W  = PROD_W - 16;

  logic [ppd_pkg::PEND_W-1:0]  pend_r, pend_nxt;
  ppd_pkg::work_t              wk_r;
  logic                        out_valid_r, out_valid_nxt;
  ppd_pkg::out_t               out_data_r, res;

  logic [ppd_pkg::PEND_W-1:0]  sel_oh, rem;
  logic                        pend_any, out_load, fire;
  logic [ppd_pkg::CODE_W-1:0]  code_sel, mag_in;
  logic [ppd_pkg::CHAN_W-1:0]  chan_sel;
  logic                        neg;
  logic [ppd_pkg::SCALE_W-1:0] scale_sel;
  logic [PROD_W-1:0]           prod;
  logic [MAG_W-1:0]            mag;
  logic [ppd_pkg::VAL_W-1:0]   smp_val, evt_mag, evt_val;
  logic [3:0]                  evt_idx;

  // lowest pending slot goes next
  assign sel_oh   = pend_r & (~pend_r + 1'b1);
  assign rem      = pend_r & ~sel_oh;
  assign pend_any = |pend_r;
  assign out_load = !out_valid_r || !out_stall;
  assign fire     = pend_any && out_load;
  assign take_ok  = !pend_any || (fire && (rem == '0));

  // sample select and scaling
  always_comb begin
    code_sel = '0;
    chan_sel = '0;
    for (int s = 0; s < ppd_pkg::NSMP; s++) begin
      code_sel = code_sel | ({ppd_pkg::CODE_W{sel_oh[ppd_pkg::P_SMP0+s]}} & wk_r.code[s]);
      chan_sel = chan_sel | ({ppd_pkg::CHAN_W{sel_oh[ppd_pkg::P_SMP0+s]}} & wk_r.chan[s]);
    end
    neg       = code_sel > ppd_pkg::CODE_MID;
    mag_in    = neg ? (code_sel - ppd_pkg::CODE_MID) : (ppd_pkg::CODE_MID - code_sel);
    scale_sel = wk_r.lfp ? lfp_scale : ap_scale;
    prod      = PROD_W'(mag_in) * PROD_W'(scale_sel);
    mag       = prod[PROD_W-1:16];
    if (!neg) begin
      smp_val = (mag > MAG_W'(32767)) ? 16'h7FFF : ppd_pkg::VAL_W'(mag);
    end else begin
      smp_val = (mag >= MAG_W'(32768)) ? 16'h8000 : (~ppd_pkg::VAL_W'(mag) + 1'b1);
    end
  end

  // event bit number and signed value
  always_comb begin
    evt_idx = '0;
    for (int c = 0; c < ppd_pkg::EVT_W; c++) begin
      if (sel_oh[ppd_pkg::P_EVT0+c]) evt_idx = evt_idx | 4'(c);
    end
    evt_mag = ppd_pkg::VAL_W'(evt_idx) + 1'b1;
    evt_val = wk_r.evt_code[evt_idx] ? evt_mag : (~evt_mag + 1'b1);
  end

  // result assembly
  always_comb begin
    res.kind    = ppd_pkg::KIND_EVENT;
    res.channel = '0;
    res.value   = '0;
    res.stamp   = wk_r.stamp;
    res.last    = (rem == '0);
    if (|sel_oh[ppd_pkg::P_SMP0 +: ppd_pkg::NSMP]) begin
      res.kind    = wk_r.lfp ? ppd_pkg::KIND_LFP : ppd_pkg::KIND_AP;
      res.channel = chan_sel;
      res.value   = smp_val;
    end else if (sel_oh[ppd_pkg::P_CORRUPT]) begin
      res.kind  = ppd_pkg::KIND_CORRUPT;
      res.stamp = wk_r.bad_stamp;
    end else if (!sel_oh[ppd_pkg::P_SPLIT]) begin
      res.value = evt_val;
    end
  end

  // next control state
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (fire) pend_nxt = rem;
    if (load) pend_nxt = load_pend;
    if (out_load) out_valid_nxt = fire;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) wk_r <= load_work;
    if (fire) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new item only lands when the previous one is fully drained
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n) load |-> take_ok)
    else $error("item loaded while results still pending");

  // a corrupt result ends the item, so no events can follow it
  a_corrupt_alone: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[ppd_pkg::P_CORRUPT] |-> (pend_r[ppd_pkg::P_EVT0 +: ppd_pkg::EVT_W] == '0))
    else $error("events pending together with corrupt result");

  // file split is the only result of its item
  a_split_alone: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[ppd_pkg::P_SPLIT] |-> $onehot(pend_r))
    else $error("file split pending with other results");

endmodule

`default_nettype wire

// ===== rtl/core/probe_packet_deframer.sv =====
// Probe packet deframer top level: word decode, framing state and configuration.
// Depends on ppd_pkg and ppd_emit.
`default_nettype none

// Takes one 32-bit stream word (or a file-start marker) per transfer and sends
// AP/LFP samples, event-bit changes, file splits and corrupt-block markers, one
// result per cycle unless out_stall holds it. A word is decoded and all framing
// state updated in the cycle it is accepted; its results are then drained by the
// serializer: up to three for a data word, up to nineteen for the last word of a
// packet when many event bits change, one for a file start, and none for a header
// or ignored word that does not end a packet. A following item is taken in the
// cycle the previous item's last result moves to the output register.
// Configuration is ready every cycle; writes are meant for idle time.
module probe_packet_deframer #(
  parameter int WORDS_PER_PACKET  = ppd_pkg::WORDS_PER_PACKET_DEF,
  parameter int PACKETS_PER_BLOCK = ppd_pkg::PACKETS_PER_BLOCK_DEF,
  parameter int AP_CHANNELS       = ppd_pkg::AP_CHANNELS_DEF,
  parameter int LFP_PER_PACKET    = ppd_pkg::LFP_PER_PACKET_DEF,
  parameter int LFP_WORD_LIMIT    = ppd_pkg::LFP_WORD_LIMIT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ppd_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ppd_pkg::out_t                         out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppd_pkg::SCALE_W-1:0]      cfg_data
);

  localparam int WP_W = $clog2(WORDS_PER_PACKET);
  localparam int PP_W = $clog2(PACKETS_PER_BLOCK + 1);
  localparam int LI_W = $clog2(LFP_PER_PACKET + 1);
  localparam int AI_W = $clog2(AP_CHANNELS + 1);
  localparam int CH_W = $clog2(LFP_PER_PACKET * PACKETS_PER_BLOCK + 16);

  localparam logic [1:0] TOP_DATA   = 2'b00;
  localparam logic [1:0] TOP_HEADER = 2'b01;

  // framing state
  logic [WP_W-1:0]                wp_r, wp_nxt;
  logic [PP_W-1:0]                pp_r, pp_nxt;
  logic [ppd_pkg::BLK_W-1:0]      blk_r, blk_nxt;
  logic [ppd_pkg::GRP_W-1:0]      grp_r, grp_nxt;
  logic [LI_W-1:0]                li_r, li_nxt;
  logic [AI_W-1:0]                ai_r, ai_nxt;
  logic [ppd_pkg::EVT_W-1:0]      pcode_r, pcode_nxt;
  logic [ppd_pkg::EVT_W-1:0]      prev_r, prev_nxt;
  logic [ppd_pkg::EVT_W-1:0]      bsc_r, bsc_nxt;
  logic [ppd_pkg::TIME_W-1:0]     time_r, time_nxt;
  logic                           halt_r, halt_nxt;

  // configuration
  logic [ppd_pkg::SCALE_W-1:0]    ap_scale_r, lfp_scale_r;
  logic [ppd_pkg::BLK_W-1:0]      blk_limit_r;

  logic                           accept, take_ok, limit_hit, work_load;
  logic [31:0]                    sw;
  logic [ppd_pkg::PEND_W-1:0]     work_pend;
  ppd_pkg::work_t                 work;
  logic [LI_W-1:0]                li_v;
  logic [AI_W-1:0]                ai_v;
  logic [CH_W-1:0]                ch_v;
  logic                           ovf_v;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !take_ok;
  assign cfg_ready = 1'b1;
  assign limit_hit = (blk_limit_r != '0) && (blk_r >= blk_limit_r);
  assign sw        = {in_data.raw_word[7:0], in_data.raw_word[15:8],
                      in_data.raw_word[23:16], in_data.raw_word[31:24]};
  assign work_load = accept && (work_pend != '0);

  // decode one item and step the framing state
  always_comb begin
    wp_nxt    = wp_r;
    pp_nxt    = pp_r;
    blk_nxt   = blk_r;
    grp_nxt   = grp_r;
    li_nxt    = li_r;
    ai_nxt    = ai_r;
    pcode_nxt = pcode_r;
    prev_nxt  = prev_r;
    bsc_nxt   = bsc_r;
    time_nxt  = time_r;
    halt_nxt  = halt_r;

    work_pend      = '0;
    work.lfp       = 32'(wp_r) < 32'(LFP_WORD_LIMIT);
    work.evt_code  = pcode_r;
    work.stamp     = time_r[ppd_pkg::STAMP_W-1:0];
    work.bad_stamp = time_r[ppd_pkg::STAMP_W-1:0];
    work.chan      = '0;
    for (int s = 0; s < ppd_pkg::NSMP; s++) begin
      work.code[s] = sw[ppd_pkg::CODE_W*s +: ppd_pkg::CODE_W];
    end

    li_v  = li_r;
    ai_v  = ai_r;
    ch_v  = '0;
    ovf_v = 1'b0;

    if (accept) begin
      if (in_data.operation) begin
        // file start
        work_pend[ppd_pkg::P_SPLIT] = 1'b1;
        halt_nxt = 1'b0;
        wp_nxt   = '0;
        pp_nxt   = '0;
        blk_nxt  = '0;
        li_nxt   = '0;
        ai_nxt   = '0;
        bsc_nxt  = prev_r;
      end else if (!halt_r && !limit_hit) begin
        case (sw[31:30])
          TOP_HEADER: begin
            pcode_nxt = sw[ppd_pkg::EVT_W-1:0];
            grp_nxt   = sw[20:17];
          end
          TOP_DATA: begin
            // three samples, each stepping the LFP or AP index until an AP overflow
            for (int s = 0; s < ppd_pkg::NSMP; s++) begin
              if (!ovf_v) begin
                if (work.lfp) begin
                  if (32'(li_v) < 32'(LFP_PER_PACKET)) begin
                    ch_v = CH_W'(li_v) * CH_W'(PACKETS_PER_BLOCK) + CH_W'(grp_r);
                    if (32'(ch_v) < 32'(AP_CHANNELS)) begin
                      work_pend[ppd_pkg::P_SMP0+s] = 1'b1;
                      work.chan[s] = ppd_pkg::CHAN_W'(ch_v);
                    end
                    li_v = li_v + 1'b1;
                  end else begin
                    li_v = '0;
                  end
                end else if (32'(ai_v) < 32'(AP_CHANNELS)) begin
                  work_pend[ppd_pkg::P_SMP0+s] = 1'b1;
                  work.chan[s] = ppd_pkg::CHAN_W'(ai_v);
                  ai_v = ai_v + 1'b1;
                end else begin
                  ovf_v = 1'b1;
                end
              end
            end
            li_nxt = li_v;
            ai_nxt = ai_v;
          end
          default: ;
        endcase

        if (ovf_v) begin
          // AP overflow: rewind to block start and halt
          time_nxt       = time_r - ppd_pkg::TIME_W'(pp_r);
          prev_nxt       = bsc_r;
          halt_nxt       = 1'b1;
          work.bad_stamp = time_nxt[ppd_pkg::STAMP_W-1:0];
          work_pend[ppd_pkg::P_CORRUPT] = 1'b1;
        end else if (32'(wp_r) == 32'(WORDS_PER_PACKET - 1)) begin
          // packet end: report changed event bits (none at timestamp zero)
          work.evt_code = pcode_nxt;
          if (time_r != '0) begin
            work_pend[ppd_pkg::P_EVT0 +: ppd_pkg::EVT_W] = pcode_nxt ^ prev_r;
          end
          prev_nxt = pcode_nxt;
          time_nxt = time_r + 1'b1;
          wp_nxt   = '0;
          li_nxt   = '0;
          ai_nxt   = '0;
          if (32'(pp_r) == 32'(PACKETS_PER_BLOCK - 1)) begin
            pp_nxt  = '0;
            blk_nxt = (blk_r == '1) ? blk_r : blk_r + 1'b1;
            bsc_nxt = pcode_nxt;
          end else begin
            pp_nxt = pp_r + 1'b1;
          end
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
      end
    end
  end

  // framing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      pp_r    <= '0;
      blk_r   <= '0;
      grp_r   <= '0;
      li_r    <= '0;
      ai_r    <= '0;
      pcode_r <= '0;
      prev_r  <= '1;
      bsc_r   <= '1;
      time_r  <= '0;
      halt_r  <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      pp_r    <= pp_nxt;
      blk_r   <= blk_nxt;
      grp_r   <= grp_nxt;
      li_r    <= li_nxt;
      ai_r    <= ai_nxt;
      pcode_r <= pcode_nxt;
      prev_r  <= prev_nxt;
      bsc_r   <= bsc_nxt;
      time_r  <= time_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // configuration writes; the block limit is kept pre-multiplied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_scale_r  <= ppd_pkg::AP_SCALE_RST;
      lfp_scale_r <= ppd_pkg::LFP_SCALE_RST;
      blk_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppd_pkg::CFG_AP_SCALE:  ap_scale_r  <= cfg_data;
        ppd_pkg::CFG_LFP_SCALE: lfp_scale_r <= cfg_data;
        ppd_pkg::CFG_SEC_LIMIT: blk_limit_r <=
          ppd_pkg::BLK_W'(cfg_data[ppd_pkg::SECS_W-1:0]) *
          ppd_pkg::BLK_W'(ppd_pkg::BLOCKS_PER_SECOND);
        default: ;
      endcase
    end
  end

  // result serializer
  ppd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (work_load),
    .load_pend (work_pend),
    .load_work (work),
    .take_ok   (take_ok),
    .ap_scale  (ap_scale_r),
    .lfp_scale (lfp_scale_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a halted block sends nothing for data words
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_data.operation && halt_r) |-> !work_load)
    else $error("results from a data word while halted");

  // an overflow leaves the block halted
  a_ovf_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (work_load && work_pend[ppd_pkg::P_CORRUPT]) |=> halt_r)
    else $error("corrupt result without halt");

  // a file start rewinds packet framing
  a_file_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.operation) |=> (wp_r == '0) && (pp_r == '0) && !halt_r)
    else $error("file start did not clear framing");

endmodule

`default_nettype wire

// ===== sim/tb_probe_packet_deframer.sv =====
// Self-checking testbench for probe_packet_deframer: directed words, a packet of
// random traffic around a register change, scoreboard with its own decoder.
// Depends on ppd_pkg and the RTL of probe_packet_deframer.

import ppd_pkg::*;

// decodes each accepted input transfer and checks results in order
class deframe_scoreboard;
  // register copies
  logic [SCALE_W-1:0] ap_scale, lfp_scale;
  logic [SECS_W-1:0]  sec_limit;
  // framing state
  int unsigned        word_pos, pkt_pos, lfp_idx, ap_idx;
  logic [BLK_W-1:0]   blocks;
  logic [GRP_W-1:0]   lfp_grp;
  logic [EVT_W-1:0]   cur_code, prev_code, blk_code;
  logic [TIME_W-1:0]  tcount;
  bit                 halted;
  // expected results, oldest first
  out_t               expected_q[$];
  // tallies
  int unsigned        errors, inputs, pkt_ends, block_ends, files;
  int unsigned        seen[4];

  function new();
    ap_scale   = AP_SCALE_RST;
    lfp_scale  = LFP_SCALE_RST;
    sec_limit  = '0;
    word_pos   = 0;
    pkt_pos    = 0;
    lfp_idx    = 0;
    ap_idx     = 0;
    blocks     = '0;
    lfp_grp    = '0;
    cur_code   = '0;
    prev_code  = '1;
    blk_code   = '1;
    tcount     = '0;
    halted     = 1'b0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    case (idx)
      CFG_AP_SCALE:  ap_scale = data;
      CFG_LFP_SCALE: lfp_scale = data;
      CFG_SEC_LIMIT: sec_limit = data[SECS_W-1:0];
      default: ;
    endcase
  endfunction

  // (512 - code) * q16 / 65536, toward zero, saturated to 16 bits
  function logic signed [VAL_W-1:0] scaled(logic [CODE_W-1:0] code, logic [SCALE_W-1:0] q16);
    longint diff, mag;
    diff = longint'(CODE_MID) - longint'(code);
    mag  = ((diff < 0) ? -diff : diff) * longint'(q16);
    mag  = mag >>> 16;
    if (diff >= 0) return (mag > 32767) ? 16'sh7FFF : 16'(mag);
    return (mag >= 32768) ? 16'sh8000 : 16'(-mag);
  endfunction

  function void add(kind_t k, int unsigned ch, logic signed [VAL_W-1:0] v);
    out_t r;
    r.kind    = k;
    r.channel = ch[CHAN_W-1:0];
    r.value   = v;
    r.stamp   = tcount[STAMP_W-1:0];
    r.last    = 1'b0;
    expected_q.push_back(r);
  endfunction

  // packet end: changed event bits, timestamp and block bookkeeping
  function void close_packet();
    int c;
    if (tcount != 0 && cur_code != prev_code) begin
      for (c = 0; c < EVT_W; c++) begin
        if (cur_code[c] != prev_code[c])
          add(KIND_EVENT, 0, cur_code[c] ? 16'(c + 1) : 16'(-(c + 1)));
      end
    end
    prev_code = cur_code;
    tcount++;
    word_pos = 0;
    lfp_idx  = 0;
    ap_idx   = 0;
    pkt_ends++;
    pkt_pos++;
    if (pkt_pos >= PACKETS_PER_BLOCK_DEF) begin
      pkt_pos = 0;
      if (blocks != '1) blocks++;
      blk_code = prev_code;
      block_ends++;
    end
  endfunction

  function void note_input(in_t item);
    int unsigned       start_n, s, ch;
    logic [31:0]       w;
    logic [CODE_W-1:0] code;
    start_n = expected_q.size();
    inputs++;
    if (item.operation == 1'b1) begin
      // file start: split event, framing restarts
      add(KIND_EVENT, 0, '0);
      halted   = 1'b0;
      word_pos = 0;
      pkt_pos  = 0;
      blocks   = '0;
      lfp_idx  = 0;
      ap_idx   = 0;
      blk_code = prev_code;
      files++;
    end else if (!halted && !(sec_limit != 0 &&
               longint'(blocks) >= longint'(BLOCKS_PER_SECOND) * longint'(sec_limit))) begin
      w = {item.raw_word[7:0], item.raw_word[15:8], item.raw_word[23:16], item.raw_word[31:24]};
      if (w[31:30] == 2'b01) begin
        cur_code = w[15:0];
        lfp_grp  = w[20:17];
      end else if (w[31:30] == 2'b00) begin
        for (s = 0; s < NSMP && !halted; s++) begin
          code = w[CODE_W*s +: CODE_W];
          if (word_pos < LFP_WORD_LIMIT_DEF) begin
            if (lfp_idx < LFP_PER_PACKET_DEF) begin
              ch = lfp_idx * PACKETS_PER_BLOCK_DEF + lfp_grp;
              if (ch < AP_CHANNELS_DEF) add(KIND_LFP, ch, scaled(code, lfp_scale));
              lfp_idx = (lfp_idx + 1) & 63;
            end else begin
              lfp_idx = 0;
            end
          end else if (ap_idx < AP_CHANNELS_DEF) begin
            add(KIND_AP, ap_idx, scaled(code, ap_scale));
            ap_idx = (ap_idx + 1) & 511;
          end else begin
            // AP overflow: rewind to the block start and halt
            tcount   -= pkt_pos;
            prev_code = blk_code;
            halted    = 1'b1;
            add(KIND_CORRUPT, 0, '0);
          end
        end
      end
      if (!halted) begin
        word_pos = (word_pos + 1) & 255;
        if (word_pos >= WORDS_PER_PACKET_DEF) close_packet();
      end
    end
    if (expected_q.size() > start_n) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function void mismatch(string field, longint exp_v, longint got_v);
    errors++;
    if (errors <= 40) $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
    else if (errors == 41) $display("further mismatches not shown");
  endfunction

  function void check_result(out_t got);
    out_t exp;
    seen[got.kind]++;
    if (expected_q.size() == 0) begin
      errors++;
      $error("unexpected result: kind %0d channel %0d value %0d stamp %0d",
             got.kind, got.channel, got.value, got.stamp);
      return;
    end
    exp = expected_q.pop_front();
    if (got.kind !== exp.kind) mismatch("kind", exp.kind, got.kind);
    if (got.channel !== exp.channel) mismatch("channel", exp.channel, got.channel);
    if (got.value !== exp.value) mismatch("value", longint'(exp.value), longint'(got.value));
    if (got.stamp !== exp.stamp) mismatch("stamp", exp.stamp, got.stamp);
    if (got.last !== exp.last) mismatch("last", exp.last, got.last);
  endfunction
endclass

module tb_probe_packet_deframer;

  localparam logic [1:0] TAG_DATA    = 2'b00;
  localparam logic [1:0] TAG_HEADER  = 2'b01;
  localparam logic [1:0] TAG_SKIP    = 2'b10;
  localparam logic [1:0] TAG_COUNTER = 2'b11;
  localparam logic       OP_WORD     = 1'b0;
  localparam logic       OP_FILE     = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk, rst_n;
  logic                 in_valid, in_stall;
  in_t                  in_data;
  logic                 out_valid, out_stall;
  out_t                 out_data;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0]   cfg_data;

  bit                   jitter;
  int unsigned          idle_cycles;
  deframe_scoreboard    sb;

  probe_packet_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= jitter && ($urandom_range(0, 99) < 33);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_probe_packet_deframer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] swap_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // stream word whose decoded form is {tag, body}
  function automatic in_t word_item(logic [1:0] tag, logic [29:0] body);
    in_t it;
    it.operation = OP_WORD;
    it.raw_word  = swap_bytes({tag, body});
    return it;
  endfunction

  function automatic in_t header_item(logic [EVT_W-1:0] code, logic [GRP_W-1:0] grp);
    return word_item(TAG_HEADER, {9'($urandom), grp, 1'($urandom), code});
  endfunction

  function automatic in_t data_item(logic [CODE_W-1:0] c0, c1, c2);
    return word_item(TAG_DATA, {c2, c1, c0});
  endfunction

  function automatic in_t file_item();
    in_t it;
    it.operation = OP_FILE;
    it.raw_word  = $urandom;
    return it;
  endfunction

  function automatic in_t noise_item();
    in_t it;
    it.operation = ($urandom_range(0, 99) < 3) ? OP_FILE : OP_WORD;
    it.raw_word  = $urandom;
    return it;
  endfunction

  // sample code, biased toward the ends and the midpoint
  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return CODE_MID;
      3: return CODE_MID - 1;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  // one input transfer, with optional idle cycles ahead of it
  task automatic send_item(input in_t item);
    while (jitter && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // idle point for register writes: results drained, zero-result items done
  task automatic settle();
    hold_until_drained();
    repeat (20) @(negedge clk);
  endtask

  // well-formed packets with random content; overflow set fills the AP area
  task automatic run_packets(input int unsigned count, input bit overflow);
    int unsigned      done, r;
    logic [EVT_W-1:0] code;
    done = 0;
    while (done < count && !sb.halted) begin
      if (sb.word_pos == 0) begin
        r = $urandom_range(0, 99);
        code = (r < 30) ? sb.cur_code : (r < 50) ? ~sb.cur_code : EVT_W'($urandom);
        send_item(header_item(code, GRP_W'($urandom)));
      end else if (!overflow && ($urandom_range(0, 99) < 12 ||
                   (sb.word_pos >= LFP_WORD_LIMIT_DEF && sb.ap_idx + NSMP > AP_CHANNELS_DEF))) begin
        r = $urandom_range(0, 99);
        if (r < 25) send_item(header_item(EVT_W'($urandom), GRP_W'($urandom)));
        else send_item(word_item(r[0] ? TAG_SKIP : TAG_COUNTER, 30'($urandom)));
      end else begin
        send_item(data_item(pick_code(), pick_code(), pick_code()));
      end
      if (sb.word_pos == 0 && !sb.halted) done++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    jitter    = 1'b1;
    sb        = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words at reset scales: tags, code extremes, no header yet
    send_item(file_item());
    send_item(data_item('0, '1, CODE_MID));
    send_item(header_item(16'hFFFF, 4'hF));
    send_item(data_item(CODE_MID - 1, CODE_MID + 1, 10'd1));
    send_item(word_item(TAG_COUNTER, 30'($urandom)));
    send_item(word_item(TAG_SKIP, 30'($urandom)));
    send_item(header_item(16'h0000, 4'd11));
    send_item(word_item(TAG_DATA, '0));
    send_item(word_item(TAG_COUNTER, '1));
    send_item(data_item(pick_code(), pick_code(), pick_code()));
    send_item(file_item());
    send_item(data_item('1, '1, '1));
    send_item(header_item(16'hA5A5, 4'd12));
    send_item(data_item('0, '0, '0));

    // burst with no idling on either side: LFP index wrap, then AP samples
    jitter = 1'b0;
    repeat (40) send_item(data_item(pick_code(), pick_code(), pick_code()));
    jitter = 1'b1;

    // sender waits for a full drain mid-packet, then new scales and a limit
    settle();
    write_register(CFG_AP_SCALE, 24'hFFFFFF);
    write_register(CFG_LFP_SCALE, 24'($urandom));
    write_register(CFG_SEC_LIMIT, 24'hFF0001);
    write_register(CFG_UNUSED, 24'($urandom));
    // rest of the packet; its end falls at timestamp zero
    run_packets(1, 1'b0);
    repeat (8) send_item(noise_item());

    // drain and wrap up
    hold_until_drained();
    repeat (40) @(negedge clk);
    $display("covered %0d input transfers, %0d AP / %0d LFP / %0d event / %0d corrupt results",
             sb.inputs, sb.seen[KIND_AP], sb.seen[KIND_LFP], sb.seen[KIND_EVENT],
             sb.seen[KIND_CORRUPT]);
    $display("%0d packet ends, %0d block ends, %0d file starts, reset and changed scales",
             sb.pkt_ends, sb.block_ends, sb.files);
    if (sb.errors == 0) begin
      $display("tb_probe_packet_deframer: PASS");
    end else begin
      $display("tb_probe_packet_deframer: FAIL");
    end
    $finish;
  end

endmodule
